>>> src/assert_macros.svh
// Assertion macros used by the selective-repeat sender back end.
// Each macro expands to one labeled concurrent assertion clocked by clk, reset by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SRS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent at the same edge.
`define SRS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/srs_pkg.sv
// Shared types, codes and helpers for the selective-repeat sender.
// Used by the front end, the request queue, the back end and the top level.
`default_nettype none
package srs_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 6;
  localparam int unsigned SEQ_SPACE       = 7;
  localparam int unsigned SEQ_W           = 3;
  localparam int unsigned SUM_W           = 13;
  localparam int unsigned CALC_W          = 18;
  localparam int unsigned PART_W          = 11;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_NONE   = 2'd2
  } kind_e_t;

  typedef enum logic [1:0] {
    TCMD_NONE    = 2'd0,
    TCMD_START   = 2'd1,
    TCMD_STOP    = 2'd2,
    TCMD_RESTART = 2'd3
  } tcmd_e_t;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NEW_ACK   = 3'd2,
    ST_STALE     = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_RESENT    = 3'd5,
    ST_NOTHING   = 3'd6
  } status_e_t;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    req_e_t                   req;
    logic [63:0]              payload_lo;
    logic [63:0]              payload_mid;
    logic [31:0]              payload_hi;
    logic signed [SUM_W-1:0]  psum;
    logic                     ack_ok;
    logic                     ack_in_range;
    logic [SEQ_W-1:0]         ack_num;
  } cmd_t;

  // Sum of the low n bytes of a word, each byte taken as signed.
  function automatic logic signed [PART_W-1:0] byte_sum(input logic [63:0] w,
                                                        input int unsigned n);
    logic signed [PART_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        s = s + PART_W'($signed(w[8*i +: 8]));
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> src/selective_repeat_sender.sv
// Selective-repeat ARQ sender. A request passes the front end (capture, byte sum, push), then the back end
// handles a send directly, an ACK with a search and slide that walk one slot a cycle,
// and a timeout by retransmitting each unacked packet (one slot-memory read each).
// The queue lets the front end take new requests while the back end walks its slots.
// Reset (rst_n, synchronous, active low) empties the window; slot contents stay unwritten.
`default_nettype none
module selective_repeat_sender
  import srs_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Request channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [63:0]        in_payload_lo,
  input  wire logic [63:0]        in_payload_mid,
  input  wire logic [31:0]        in_payload_hi,
  input  wire logic [15:0]        in_pkt_seq,
  input  wire logic [15:0]        in_pkt_ack,
  input  wire logic [15:0]        in_pkt_checksum,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic [SEQ_W-1:0]        out_seq,
  output logic signed [SUM_W-1:0] out_checksum,
  output logic [63:0]             out_payload_lo,
  output logic [63:0]             out_payload_mid,
  output logic [31:0]             out_payload_hi,
  output logic [1:0]              out_timer_cmd,
  output logic [2:0]              out_status,
  output logic                    out_last
);

  // The front end classifies each request and computes its byte sum; the
  // queue lets it take the next request while the back end is still walking
  // the window for the previous one.
  cmd_t push_data, pop_data;
  logic push, full, pop, not_empty;

  srs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_payload_lo   (in_payload_lo),
    .in_payload_mid  (in_payload_mid),
    .in_payload_hi   (in_payload_hi),
    .in_pkt_seq      (in_pkt_seq),
    .in_pkt_ack      (in_pkt_ack),
    .in_pkt_checksum (in_pkt_checksum),
    .q_push          (push),
    .q_push_data     (push_data),
    .q_full          (full)
  );

  srs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  // The back end owns all window state and the registered result port, so a
  // stalled result does not block the front end from taking requests until the queue fills.
  srs_back #(
    .W (WINDOW_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (not_empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_seq         (out_seq),
    .out_checksum    (out_checksum),
    .out_payload_lo  (out_payload_lo),
    .out_payload_mid (out_payload_mid),
    .out_payload_hi  (out_payload_hi),
    .out_timer_cmd   (out_timer_cmd),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

>>> src/srs_front.sv
// Front end: takes requests, forms the payload byte sum and checks ACK checksums.
// Depends on srs_pkg; pushes cmd_t records into srs_queue.
`default_nettype none
module srs_front
  import srs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_req_type,
  input  wire logic [63:0]  in_payload_lo,
  input  wire logic [63:0]  in_payload_mid,
  input  wire logic [31:0]  in_payload_hi,
  input  wire logic [15:0]  in_pkt_seq,
  input  wire logic [15:0]  in_pkt_ack,
  input  wire logic [15:0]  in_pkt_checksum,
  output logic              q_push,
  output cmd_t              q_push_data,
  input  wire logic         q_full
);

  typedef enum logic [1:0] {F_IDLE, F_SUM, F_PUSH} fstate_t;

  fstate_t                  state_r;
  req_e_t                   req_r;
  logic [63:0]              lo_r, mid_r;
  logic [31:0]              hi_r;
  logic [15:0]              pseq_r, pack_r, pchk_r;
  logic signed [PART_W-1:0] s_lo_r, s_mid_r, s_hi_r;
  logic signed [SUM_W-1:0]  psum;
  logic signed [CALC_W-1:0] calc;

  assign in_stall = (state_r != F_IDLE);

  assign psum = SUM_W'(s_lo_r) + SUM_W'(s_mid_r) + SUM_W'(s_hi_r);
  assign calc = CALC_W'($signed(pseq_r)) + CALC_W'($signed(pack_r)) + CALC_W'(psum);

  always_comb begin
    q_push_data.req          = req_r;
    q_push_data.payload_lo   = lo_r;
    q_push_data.payload_mid  = mid_r;
    q_push_data.payload_hi   = hi_r;
    q_push_data.psum         = psum;
    q_push_data.ack_ok       = (calc == CALC_W'($signed(pchk_r)));
    q_push_data.ack_in_range = !pack_r[15] && (pack_r[14:0] < 15'(SEQ_SPACE));
    q_push_data.ack_num      = pack_r[SEQ_W-1:0];
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            req_r  <= req_e_t'(in_req_type);
            lo_r   <= in_payload_lo;
            mid_r  <= in_payload_mid;
            hi_r   <= in_payload_hi;
            pseq_r <= in_pkt_seq;
            pack_r <= in_pkt_ack;
            pchk_r <= in_pkt_checksum;
            // An unknown request type yields nothing and is dropped here.
            if (req_e_t'(in_req_type) != REQ_NONE) begin
              state_r <= F_SUM;
            end
          end
        end
        F_SUM: begin
          s_lo_r  <= byte_sum(lo_r, 8);
          s_mid_r <= byte_sum(mid_r, 8);
          s_hi_r  <= byte_sum({32'd0, hi_r}, 4);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/srs_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on srs_pkg for the cmd_t record.
`default_nettype none
module srs_queue
  import srs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      not_empty
);

  cmd_t       entry_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/srs_back.sv
// Back end: window state, slot memory, ACK search, slide and timeout walk.
// Depends on srs_pkg and assert_macros.svh; drives the registered result port.
`default_nettype none
`include "assert_macros.svh"
module srs_back
  import srs_pkg::*;
#(
  parameter int unsigned W = WINDOW_SIZE_DEF
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  cmd_t                     q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_kind,
  output logic [SEQ_W-1:0]         out_seq,
  output logic signed [SUM_W-1:0]  out_checksum,
  output logic [63:0]              out_payload_lo,
  output logic [63:0]              out_payload_mid,
  output logic [31:0]              out_payload_hi,
  output logic [1:0]               out_timer_cmd,
  output logic [2:0]               out_status,
  output logic                     out_last
);

  localparam int unsigned IDX_W = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned CNT_W = $clog2(W + 1);

  typedef struct packed {
    logic [63:0]             lo;
    logic [63:0]             mid;
    logic [31:0]             hi;
    logic signed [SUM_W-1:0] sum;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_ACK, S_SRCH, S_SLIDE, S_REPLY, S_TO_SCAN, S_TO_EMIT
  } state_t;

  state_t                  state_r;
  cmd_t                    cmd_r;
  logic [IDX_W-1:0]        head_r, tail_r, hit_idx_r;
  logic [CNT_W-1:0]        fill_r, unacked_r, walk_r, sent_r;
  logic [SEQ_W-1:0]        nseq_r;
  status_e_t               reply_r;
  logic [W-1:0]            acked_r;
  logic [SEQ_W-1:0]        seq_r [W];
  slot_t                   mem [W];
  slot_t                   rd_data_r;

  logic                    out_free, out_load;
  logic [IDX_W:0]          wsum;
  logic [IDX_W-1:0]        walk_idx, tail_nxt, head_nxt;
  logic signed [SUM_W-1:0] send_sum;
  logic                    win_full, mem_we, mem_re, last_resend;

  assign out_free = !out_valid || !out_stall;
  // A new result is loaded into the output register in one of the emitting states.
  assign out_load = out_free && ((state_r == S_SEND) || (state_r == S_REPLY) ||
                                 (state_r == S_TO_EMIT));
  assign q_pop    = (state_r == S_IDLE) && q_not_empty;

  assign wsum     = {1'b0, head_r} + (IDX_W + 1)'(walk_r);
  assign walk_idx = (wsum >= (IDX_W + 1)'(W)) ? IDX_W'(wsum - (IDX_W + 1)'(W))
                                              : IDX_W'(wsum);
  assign tail_nxt = (tail_r == IDX_W'(W - 1)) ? '0 : tail_r + IDX_W'(1);
  assign head_nxt = (head_r == IDX_W'(W - 1)) ? '0 : head_r + IDX_W'(1);
  assign send_sum = $signed({{(SUM_W - SEQ_W){1'b0}}, nseq_r}) + cmd_r.psum
                    - SUM_W'(1);
  assign win_full = (fill_r == CNT_W'(W));
  assign mem_we   = (state_r == S_SEND) && out_free && !win_full;
  assign mem_re   = (state_r == S_TO_SCAN) && !acked_r[walk_idx];
  assign last_resend = ((sent_r + CNT_W'(1)) == unacked_r);

  // Slot memory: written on a send into a free slot, read one slot at a time on a timeout.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_nxt] <= '{lo: cmd_r.payload_lo, mid: cmd_r.payload_mid,
                         hi: cmd_r.payload_hi, sum: send_sum};
    end
    if (mem_re) begin
      rd_data_r <= mem[walk_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= IDX_W'(W - 1);
      fill_r    <= '0;
      unacked_r <= '0;
      nseq_r    <= '0;
      acked_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            cmd_r  <= q_data;
            walk_r <= '0;
            sent_r <= '0;
            case (q_data.req)
              REQ_SEND: state_r <= S_SEND;
              REQ_ACK:  state_r <= S_ACK;
              default: begin
                if (unacked_r == '0) begin
                  reply_r <= ST_NOTHING;
                  state_r <= S_REPLY;
                end else begin
                  state_r <= S_TO_SCAN;
                end
              end
            endcase
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_last        <= 1'b1;
            out_payload_lo  <= '0;
            out_payload_mid <= '0;
            out_payload_hi  <= '0;
            out_seq         <= '0;
            out_checksum    <= '0;
            if (win_full) begin
              out_kind      <= KIND_NONE;
              out_timer_cmd <= TCMD_NONE;
              out_status    <= ST_FULL;
            end else begin
              tail_r            <= tail_nxt;
              seq_r[tail_nxt]   <= nseq_r;
              acked_r[tail_nxt] <= 1'b0;
              fill_r            <= fill_r + CNT_W'(1);
              unacked_r         <= unacked_r + CNT_W'(1);
              nseq_r            <= (nseq_r == SEQ_W'(SEQ_SPACE - 1)) ? '0
                                                                      : nseq_r + SEQ_W'(1);
              out_kind          <= KIND_NEW;
              out_seq           <= nseq_r;
              out_checksum      <= send_sum;
              out_payload_lo    <= cmd_r.payload_lo;
              out_payload_mid   <= cmd_r.payload_mid;
              out_payload_hi    <= cmd_r.payload_hi;
              out_timer_cmd     <= (unacked_r == '0) ? TCMD_START : TCMD_NONE;
              out_status        <= ST_SENT;
            end
            state_r <= S_IDLE;
          end
        end
        S_ACK: begin
          if (!cmd_r.ack_ok) begin
            reply_r <= ST_CORRUPT;
            state_r <= S_REPLY;
          end else begin
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (walk_r == fill_r) begin
            reply_r <= ST_STALE;
            state_r <= S_REPLY;
          end else if (cmd_r.ack_in_range && (seq_r[walk_idx] == cmd_r.ack_num)) begin
            if (acked_r[walk_idx]) begin
              reply_r <= ST_STALE;
              state_r <= S_REPLY;
            end else begin
              acked_r[walk_idx] <= 1'b1;
              unacked_r         <= unacked_r - CNT_W'(1);
              reply_r           <= ST_NEW_ACK;
              state_r           <= (walk_idx == head_r) ? S_SLIDE : S_REPLY;
            end
          end else begin
            walk_r <= walk_r + CNT_W'(1);
          end
        end
        S_SLIDE: begin
          if ((fill_r != '0) && acked_r[head_r]) begin
            head_r <= head_nxt;
            fill_r <= fill_r - CNT_W'(1);
          end else begin
            state_r <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_last        <= 1'b1;
            out_kind        <= KIND_NONE;
            out_seq         <= '0;
            out_checksum    <= '0;
            out_payload_lo  <= '0;
            out_payload_mid <= '0;
            out_payload_hi  <= '0;
            out_status      <= reply_r;
            if (reply_r == ST_NEW_ACK) begin
              out_timer_cmd <= ((fill_r != '0) && (unacked_r != '0)) ? TCMD_RESTART
                                                                     : TCMD_STOP;
            end else begin
              out_timer_cmd <= TCMD_NONE;
            end
            state_r <= S_IDLE;
          end
        end
        S_TO_SCAN: begin
          if (!acked_r[walk_idx]) begin
            hit_idx_r <= walk_idx;
            state_r   <= S_TO_EMIT;
          end else begin
            walk_r <= walk_r + CNT_W'(1);
          end
        end
        S_TO_EMIT: begin
          if (out_free) begin
            out_kind        <= KIND_RESEND;
            out_seq         <= seq_r[hit_idx_r];
            out_checksum    <= rd_data_r.sum;
            out_payload_lo  <= rd_data_r.lo;
            out_payload_mid <= rd_data_r.mid;
            out_payload_hi  <= rd_data_r.hi;
            out_status      <= ST_RESENT;
            out_last        <= last_resend;
            out_timer_cmd   <= last_resend ? TCMD_START : TCMD_NONE;
            sent_r          <= sent_r + CNT_W'(1);
            walk_r          <= walk_r + CNT_W'(1);
            state_r         <= last_resend ? S_IDLE : S_TO_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SRS_ASSERT(a_fill_bound, fill_r <= CNT_W'(W), "window fill exceeds window size")
  `SRS_ASSERT(a_unacked_le_fill, unacked_r <= fill_r, "more unacked slots than filled slots")
  `SRS_IMPLIES(a_head_unacked, (state_r == S_IDLE) && (fill_r != '0), !acked_r[head_r], "acked slot left at window head")

endmodule
`default_nettype wire
